// ----- hw/rtl/pvee_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pvee_pkg;

  // Voice slots
  localparam int VOICES = 6;
  localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SLOT_W = 4;

  // Divider: quotients always fit 16 bits
  localparam int DIV_BITS = 16;
  localparam int DCNT_W   = $clog2(DIV_BITS);

  // Command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  // Slot modes
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_ON  = 2'd1;
  localparam logic [1:0] MODE_REL = 2'd2;

  // Register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PEAK    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DECAY   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd4;
  localparam int REG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] ATTACK_RST  = 16'd250;
  localparam logic [14:0] PEAK_RST    = 15'd29491;
  localparam logic [15:0] DECAY_RST   = 16'd5000;
  localparam logic [14:0] SUSTAIN_RST = 15'd6554;
  localparam logic [15:0] RELEASE_RST = 16'd10000;

  localparam logic [23:0] AGE_MAX = 24'hFFFFFF;
  localparam logic [15:0] RC_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] note;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              active;
    logic [6:0]        voice_note;
    logic [14:0]       level;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  pitch;
    logic [23:0] age;
    logic [15:0] rc;
    logic [14:0] held;
  } voice_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    voice_t           data;
  } vf_wr_t;

  // Multiply-divide request: a * b / den
  typedef struct packed {
    logic [14:0] a;
    logic [15:0] b;
    logic [15:0] den;
  } md_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quot;
  } md_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pvee_muldiv.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared unit: a multiply step, then restoring divide, one bit per cycle.
module pvee_muldiv
  import pvee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire md_req_t  req,
  output md_stat_t      stat
);

  localparam logic [1:0] MD_IDLE = 2'd0;
  localparam logic [1:0] MD_MUL  = 2'd1;
  localparam logic [1:0] MD_DIV  = 2'd2;

  logic [1:0]        md_state;
  logic              done;
  logic [14:0]       a_q;
  logic [15:0]       b_q;
  logic [15:0]       den_q;
  logic [15:0]       rem;
  logic [15:0]       qsh;
  logic [DCNT_W-1:0] cnt;
  logic [30:0]       prod;
  logic [16:0]       trial;
  logic              qbit;
  logic [15:0]       rem_next;

  assign prod     = a_q * b_q;
  assign trial    = {rem, qsh[15]};
  assign qbit     = trial >= {1'b0, den_q};
  assign rem_next = qbit ? 16'(trial - {1'b0, den_q}) : trial[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      md_state <= MD_IDLE;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (md_state)
        MD_IDLE: begin
          if (start) begin
            md_state <= MD_MUL;
          end
        end
        MD_MUL: begin
          md_state <= MD_DIV;
        end
        MD_DIV: begin
          if (cnt == DCNT_W'(DIV_BITS - 1)) begin
            md_state <= MD_IDLE;
            done     <= 1'b1;
          end
        end
        default: begin
          md_state <= MD_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (md_state)
      MD_IDLE: begin
        if (start) begin
          a_q   <= req.a;
          b_q   <= req.b;
          den_q <= req.den;
        end
      end
      MD_MUL: begin
        // high half is below den since the quotient fits 16 bits
        rem <= {1'b0, prod[30:16]};
        qsh <= prod[15:0];
        cnt <= '0;
      end
      MD_DIV: begin
        rem <= rem_next;
        qsh <= {qsh[14:0], qbit};
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign stat.busy = md_state != MD_IDLE;
  assign stat.done = done;
  assign stat.quot = qsh;

endmodule

`default_nettype wire

// ----- hw/rtl/pvee_voice_file.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Per-slot state, one read and one write index.
module pvee_voice_file
  import pvee_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] rd_idx,
  output voice_t                rd_data,
  input  wire vf_wr_t           wr
);

  voice_t slots [VOICES];

  assign rd_data = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        slots[i] <= '0;
      end
    end else if (wr.en) begin
      slots[wr.idx] <= wr.data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/poly_voice_envelope_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Polyphonic ADSR envelope engine. Pulse start with an item while busy is low.
// A note-on scans the slots one per cycle and claims the first off slot, or
// steals the oldest one (ties to the lowest slot). A note-off releases
// matching sounding slots. A tick walks the slots
// and puts one result per slot on the result port, each for exactly one cycle
// with strobe high; the receiver cannot stall, so it must take every beat.
// A slot whose level needs a ramp uses the shared multiply/divide unit (a
// multiply step, then a restoring divide), so a slot takes longer with a ramp
// than without; a full tick walks every slot, the last beat showing in the
// same cycle that busy drops. Command code 3 is taken and ignored.
// Register writes go in at any edge with wr_en high; indexes beyond 4 are
// dropped. Write registers only while the block is idle.
module poly_voice_envelope_engine_core
  import pvee_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire in_t                   item,
  output logic                       busy,
  output logic                       strobe,
  output out_t                       result,
  input  wire logic                  wr_en,
  input  wire logic [REG_IDX_W-1:0]  wr_index,
  input  wire logic [REG_DATA_W-1:0] wr_data
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ON_SCAN  = 3'd1;
  localparam logic [2:0] ST_ON_WR    = 3'd2;
  localparam logic [2:0] ST_OFF_SCAN = 3'd3;
  localparam logic [2:0] ST_TK_EVAL  = 3'd4;
  localparam logic [2:0] ST_TK_WAIT  = 3'd5;
  localparam logic [2:0] ST_TK_OUT   = 3'd6;

  // how the quotient turns into the level
  localparam logic [1:0] FIN_Q   = 2'd0;
  localparam logic [1:0] FIN_SUB = 2'd1;
  localparam logic [1:0] FIN_ADD = 2'd2;

  // config registers
  logic [15:0] attack_samples;
  logic [14:0] attack_peak;
  logic [15:0] decay_samples;
  logic [14:0] sustain_level;
  logic [15:0] release_samples;

  // sequencer
  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [IDX_W-1:0] idx;
  logic             idx_last;
  logic [6:0]       note_q;

  // note-on search
  logic             found;
  logic [IDX_W-1:0] pick;
  logic [23:0]      best_age;

  // level calc
  logic [14:0] lvl;
  logic [14:0] base;
  logic [1:0]  fin;

  // voice file
  logic [IDX_W-1:0] rd_idx;
  voice_t           v;
  vf_wr_t           wr;

  // shared unit
  logic     md_start;
  md_req_t  md_req;
  md_stat_t md_stat;

  // envelope decode of the slot being read
  logic [16:0] ad_sum;
  logic        in_attack;
  logic        in_decay;
  logic [15:0] x_dec;
  logic        peak_ge;
  logic [14:0] pk_diff;
  logic        rel_over;
  logic        act;
  out_t        result_next;

  assign busy     = state != ST_IDLE;
  assign idx_last = idx == IDX_W'(VOICES - 1);
  assign rd_idx   = (state == ST_ON_WR) ? pick : idx;

  pvee_voice_file u_vf (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (rd_idx),
    .rd_data (v),
    .wr      (wr)
  );

  pvee_muldiv u_md (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .req   (md_req),
    .stat  (md_stat)
  );

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_samples  <= ATTACK_RST;
      attack_peak     <= PEAK_RST;
      decay_samples   <= DECAY_RST;
      sustain_level   <= SUSTAIN_RST;
      release_samples <= RELEASE_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_ATTACK:  attack_samples  <= wr_data;
        REG_PEAK:    attack_peak     <= wr_data[14:0];
        REG_DECAY:   decay_samples   <= wr_data;
        REG_SUSTAIN: sustain_level   <= wr_data[14:0];
        REG_RELEASE: release_samples <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------- envelope decode
  assign ad_sum    = {1'b0, attack_samples} + {1'b0, decay_samples};
  assign in_attack = v.age < {8'd0, attack_samples};
  assign in_decay  = {1'b0, v.age} < {8'd0, ad_sum};
  // only used inside decay, where age - attack < decay fits 16 bits
  assign x_dec     = v.age[15:0] - attack_samples;
  assign peak_ge   = sustain_level <= attack_peak;
  assign pk_diff   = peak_ge ? (attack_peak - sustain_level)
                             : (sustain_level - attack_peak);
  assign rel_over  = v.rc > release_samples;
  assign act       = v.mode != MODE_OFF;

  always_comb begin
    md_start   = 1'b0;
    md_req     = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (item.cmd)
            CMD_ON:   state_next = ST_ON_SCAN;
            CMD_OFF:  state_next = ST_OFF_SCAN;
            CMD_TICK: state_next = ST_TK_EVAL;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ON_SCAN: begin
        if (idx_last) begin
          state_next = ST_ON_WR;
        end
      end
      ST_ON_WR: begin
        state_next = ST_IDLE;
      end
      ST_OFF_SCAN: begin
        if (idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_TK_EVAL: begin
        state_next = ST_TK_OUT;
        if (v.mode == MODE_ON) begin
          if (in_attack) begin
            md_start   = 1'b1;
            md_req     = '{a: attack_peak, b: v.age[15:0], den: attack_samples};
            state_next = ST_TK_WAIT;
          end else if (in_decay) begin
            md_start   = 1'b1;
            md_req     = '{a: pk_diff, b: x_dec, den: decay_samples};
            state_next = ST_TK_WAIT;
          end
        end else if (v.mode == MODE_REL) begin
          if (!rel_over && release_samples != '0) begin
            md_start   = 1'b1;
            md_req     = '{a: v.held, b: v.rc, den: release_samples};
            state_next = ST_TK_WAIT;
          end
        end
      end
      ST_TK_WAIT: begin
        if (md_stat.done) begin
          state_next = ST_TK_OUT;
        end
      end
      ST_TK_OUT: begin
        state_next = idx_last ? ST_IDLE : ST_TK_EVAL;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE:     idx <= '0;
        ST_ON_SCAN,
        ST_OFF_SCAN: idx <= idx_last ? '0 : idx + 1'b1;
        ST_TK_OUT:   idx <= idx_last ? '0 : idx + 1'b1;
        default: begin
        end
      endcase
    end
  end

  // search and level datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        note_q <= item.note;
        found  <= 1'b0;
      end
      ST_ON_SCAN: begin
        if (!found) begin
          if (v.mode == MODE_OFF) begin
            found <= 1'b1;
            pick  <= idx;
          end else if (idx == '0 || v.age > best_age) begin
            pick     <= idx;
            best_age <= v.age;
          end
        end
      end
      ST_TK_EVAL: begin
        fin  <= FIN_Q;
        base <= '0;
        lvl  <= '0;
        if (v.mode == MODE_ON) begin
          if (in_attack) begin
            fin <= FIN_Q;
          end else if (in_decay) begin
            fin  <= peak_ge ? FIN_SUB : FIN_ADD;
            base <= attack_peak;
          end else begin
            lvl <= sustain_level;
          end
        end else if (v.mode == MODE_REL) begin
          fin  <= FIN_SUB;
          base <= v.held;
          if (!rel_over && release_samples == '0) begin
            lvl <= v.held;
          end
        end
      end
      ST_TK_WAIT: begin
        if (md_stat.done) begin
          case (fin)
            FIN_SUB: lvl <= base - md_stat.quot[14:0];
            FIN_ADD: lvl <= base + md_stat.quot[14:0];
            default: lvl <= md_stat.quot[14:0];
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------ write-back
  always_comb begin
    wr      = '0;
    wr.idx  = rd_idx;
    wr.data = v;
    case (state)
      ST_ON_WR: begin
        wr.en         = 1'b1;
        wr.data.mode  = MODE_ON;
        wr.data.pitch = note_q;
        wr.data.age   = '0;
        wr.data.rc    = '0;
      end
      ST_OFF_SCAN: begin
        if (act && v.pitch == note_q) begin
          wr.en        = 1'b1;
          wr.data.mode = MODE_REL;
          wr.data.rc   = '0;
        end
      end
      ST_TK_OUT: begin
        wr.en = act;
        if (v.mode == MODE_ON) begin
          wr.data.held = lvl;
        end
        if (v.mode == MODE_REL && rel_over) begin
          // release finished: slot goes off, counters stop
          wr.data.mode = MODE_OFF;
        end else begin
          if (v.age != AGE_MAX) begin
            wr.data.age = v.age + 1'b1;
          end
          if (v.mode == MODE_REL && v.rc != RC_MAX) begin
            wr.data.rc = v.rc + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------- result beat
  always_comb begin
    result_next.slot       = SLOT_W'(idx);
    result_next.active     = act;
    result_next.voice_note = act ? v.pitch : 7'd0;
    result_next.level      = lvl;
    result_next.last       = idx_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= state == ST_TK_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_TK_OUT) begin
      result <= result_next;
    end
  end

  // ------------------------------------------------------------ assertions
  a_beat_from_out: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == ST_TK_OUT)
    else $error("result beat without a slot output step");

  a_last_ends_tick: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |-> !busy)
    else $error("sequencer still busy after the last slot beat");

  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !md_stat.busy)
    else $error("shared unit running while sequencer is idle");

  a_wait_unit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TK_WAIT && !md_stat.done) |-> md_stat.busy)
    else $error("waiting on an idle shared unit");

endmodule

`default_nettype wire
